>>> rtl/hkmg_pkg.sv
// Package for the hunt-and-kill maze generator.
// Holds grid size constants, result kinds and the result item type.
// No dependencies.
`default_nettype none
package hkmg_pkg;
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int DIM_W          = 7;
   localparam int PIX_W          = 8;
   localparam int RAND_W         = 16;
   localparam logic [DIM_W-1:0] GRID_RESET = 7'd16;

   localparam logic KIND_PIXEL   = 1'b0;
   localparam logic KIND_RESTART = 1'b1;
   localparam logic OP_RESTART   = 1'b0;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   typedef struct packed {
      logic kind;
      logic [PIX_W-1:0] pix_x;
      logic [PIX_W-1:0] pix_y;
      logic finished;
      logic last;
   } rsp_item_type;

   // residue of r modulo n, n in 1..4
   function automatic logic [1:0] mod_small(input logic [RAND_W-1:0] r,
                                            input logic [2:0] n);
      logic [4:0] s1;
      logic [2:0] s2;
      logic [2:0] s3;
      logic [1:0] m;
      // r mod 3 via base-4 digit sums, 4 = 1 mod 3
      s1 = '0;
      for (int i = 0; i < RAND_W / 2; i++) begin
         s1 = s1 + 5'(r[2*i +: 2]);
      end
      s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
      s3 = 3'(s2[1:0]) + 3'(s2[2]);
      m = 2'd0;
      case (n)
         3'd2: m = {1'b0, r[0]};
         3'd3: m = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
         3'd4: m = r[1:0];
         default: m = 2'd0;
      endcase
      return m;
   endfunction
endpackage
`default_nettype wire

>>> rtl/hkmg_visited_ram.sv
// Visited bitmap: one bit per cell, registered synchronous read.
// Does not depend on hkmg_pkg; its size comes only from its parameters.
`default_nettype none
module hkmg_visited_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic          wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic               rd_data
);
   logic mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/hunt_and_kill_maze_generator.sv
// Top level of the hunt-and-kill maze generator: sequencer plus bitmap.
// Depends on hkmg_pkg and hkmg_visited_ram.
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | op, rand_hunt, rand_walk
//  rsp     | out       | rsp_valid/stall   | kind, pix_x, pix_y, finished, last
//  csr     | in        | csr_wr_en         | csr_index, csr_data
//
// A walk step runs: mark, four pipelined neighbor reads plus a capture of the last
// read, decide, one emit state per result, idle. A hunt reads each scan cell; a
// visited cell moves on, an unvisited one also reads its neighbors and decides,
// all before the walk part. Reset and every restart run a clearing pass over all
// 2**(XW+YW) bitmap entries (4096 by default); no item is taken meanwhile.
// rsp_stall holds the result register and delays the sequencer.
`default_nettype none
module hunt_and_kill_maze_generator
   import hkmg_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_op,
   input  wire logic [RAND_W-1:0] req_rand_hunt,
   input  wire logic [RAND_W-1:0] req_rand_walk,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_kind,
   output logic [PIX_W-1:0]       rsp_pix_x,
   output logic [PIX_W-1:0]       rsp_pix_y,
   output logic                   rsp_finished,
   output logic                   rsp_last,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [DIM_W-1:0]  csr_data
);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int AW    = XW + YW;
   localparam int DEPTH = 1 << AW;
   localparam int CW    = XW + 1;
   localparam int HW    = YW + 1;
   localparam int RST_W = (int'(GRID_RESET) > MAX_WIDTH) ? MAX_WIDTH : int'(GRID_RESET);
   localparam int RST_H = (int'(GRID_RESET) > MAX_HEIGHT) ? MAX_HEIGHT : int'(GRID_RESET);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_HCELL, S_HCHK, S_NB, S_DEC, S_WMARK, S_EMIT1, S_EMIT2
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [DIM_W-1:0]  gw_ff, gw_in, gh_ff, gh_in;
   logic [XW-1:0]     wx_ff, wx_in, hx_ff, hx_in;
   logic [YW-1:0]     wy_ff, wy_in, hy_ff, hy_in;
   logic              hunt_ff, hunt_in;
   logic [2:0]        nb_ff, nb_in;     // next neighbor to read, 4 = all issued
   logic              pend_ff, pend_in; // read in flight for neighbor nb_ff-1
   logic [3:0]        mask_ff, mask_in;
   logic [RAND_W-1:0] rh_ff, rh_in, rw_ff, rw_in;
   logic [PIX_W-1:0]  fpx_ff, fpx_in, fpy_ff, fpy_in;
   logic [PIX_W-1:0]  wpx_ff, wpx_in, wpy_ff, wpy_in;
   logic              fin_ff, fin_in, lst_ff, lst_in, two_ff, two_in;
   rsp_item_type      res_ff, res_in;
   logic              rv_ff, rv_in;

   logic [CW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic          wr_en, wr_data, rd_data;
   logic [AW-1:0] wr_addr, rd_addr;

   always_comb begin
      if (gw_ff == '0) w_eff = CW'(1);
      else if (int'(gw_ff) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(gw_ff);
      if (gh_ff == '0) h_eff = HW'(1);
      else if (int'(gh_ff) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
      else h_eff = HW'(gh_ff);
      cx = (CW'(wx_ff) >= w_eff) ? XW'(w_eff - CW'(1)) : wx_ff;
      cy = (HW'(wy_ff) >= h_eff) ? YW'(h_eff - HW'(1)) : wy_ff;
   end

   function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x, input logic [YW-1:0] y);
      return {y, x};
   endfunction

   function automatic rsp_item_type make_item(input logic k, input logic [PIX_W-1:0] px,
                                              input logic [PIX_W-1:0] py, input logic fin,
                                              input logic lst);
      rsp_item_type r;
      r.kind = k;
      r.pix_x = px;
      r.pix_y = py;
      r.finished = fin;
      r.last = lst;
      return r;
   endfunction

   // neighbors of the scan cell (hunting) or of the walker, left, up, right, down
   logic [XW-1:0] bx, ox[4];
   logic [YW-1:0] by, oy[4];
   logic [3:0]    ok;
   always_comb begin
      bx = hunt_ff ? hx_ff : wx_ff;
      by = hunt_ff ? hy_ff : wy_ff;
      ox[0] = bx - XW'(1); oy[0] = by;          ok[0] = bx != '0;
      ox[1] = bx;          oy[1] = by - YW'(1); ok[1] = by != '0;
      ox[2] = bx + XW'(1); oy[2] = by;
      ok[2] = (CW'(bx) + CW'(1)) < w_eff;
      ox[3] = bx;          oy[3] = by + YW'(1);
      ok[3] = (HW'(by) + HW'(1)) < h_eff;
   end

   // choose entry pick among set mask bits
   logic [2:0]        cnt;
   logic [RAND_W-1:0] rsel;
   logic [1:0]        pick, sel;
   always_comb begin
      cnt = 3'(mask_ff[0]) + 3'(mask_ff[1]) + 3'(mask_ff[2]) + 3'(mask_ff[3]);
      rsel = hunt_ff ? rh_ff : rw_ff;
      pick = mod_small(rsel, cnt);
      sel = 2'd0;
      for (int k = 0; k < 4; k++) begin
         if (mask_ff[k] && 2'($countones(mask_ff & ((4'd1 << k) - 4'd1))) == pick)
            sel = 2'(k);
      end
   end

   logic       out_free, y_wrap, x_end, advance;
   logic [1:0] prev;
   assign out_free = !rv_ff || !rsp_stall;
   assign y_wrap   = (HW'(hy_ff) + HW'(1)) >= h_eff;
   assign x_end    = (CW'(hx_ff) + CW'(1)) >= w_eff;
   assign prev     = nb_ff[1:0] - 2'd1;

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; gw_in = gw_ff; gh_in = gh_ff;
      wx_in = wx_ff; wy_in = wy_ff; hx_in = hx_ff; hy_in = hy_ff;
      hunt_in = hunt_ff; nb_in = nb_ff; pend_in = 1'b0; mask_in = mask_ff;
      rh_in = rh_ff; rw_in = rw_ff;
      fpx_in = fpx_ff; fpy_in = fpy_ff; wpx_in = wpx_ff; wpy_in = wpy_ff;
      fin_in = fin_ff; lst_in = lst_ff; two_in = two_ff;
      res_in = res_ff;
      rv_in = rv_ff && rsp_stall;
      wr_en = 1'b0; wr_addr = addr_of(wx_ff, wy_ff); wr_data = 1'b1;
      rd_addr = addr_of(hx_ff, hy_ff);
      req_stall = 1'b1;
      advance = 1'b0;
      if (csr_wr_en) begin
         if (csr_index == CSR_WIDTH) gw_in = csr_data;
         else gh_in = csr_data;
      end
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1; wr_addr = clr_ff; wr_data = 1'b0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               if (req_op == OP_RESTART) begin
                  res_in = make_item(KIND_RESTART, '0, '0, 1'b0, 1'b1);
                  rv_in = 1'b1;
                  wx_in = XW'(w_eff >> 1); wy_in = YW'(h_eff >> 1);
                  hunt_in = 1'b0; clr_in = '0; state_in = S_CLEAR;
               end else begin
                  rh_in = req_rand_hunt; rw_in = req_rand_walk;
                  wx_in = cx; wy_in = cy;
                  fpx_in = PIX_W'({cx, 1'b1}); fpy_in = PIX_W'({cy, 1'b1});
                  fin_in = 1'b0; lst_in = 1'b0; two_in = 1'b0;
                  hx_in = '0; hy_in = '0;
                  state_in = hunt_ff ? S_HCELL : S_WMARK;
               end
            end
         end
         S_HCELL: begin
            rd_addr = addr_of(hx_ff, hy_ff);
            state_in = S_HCHK;
         end
         S_HCHK: begin
            if (rd_data) advance = 1'b1;
            else begin
               nb_in = 3'd0; mask_in = '0; state_in = S_NB;
            end
         end
         S_NB: begin
            if (pend_ff) mask_in[prev] = ok[prev] && (rd_data == hunt_ff);
            if (nb_ff == 3'd4) state_in = S_DEC;
            else begin
               rd_addr = addr_of(ox[nb_ff[1:0]], oy[nb_ff[1:0]]);
               pend_in = 1'b1; nb_in = nb_ff + 3'd1;
            end
         end
         S_DEC: begin
            if (hunt_ff) begin
               if (mask_ff == '0) advance = 1'b1;
               else begin
                  wx_in = ox[sel]; wy_in = oy[sel];
                  hunt_in = 1'b0; state_in = S_WMARK;
               end
            end else if (mask_ff == '0) begin
               hunt_in = 1'b1; lst_in = 1'b1; two_in = 1'b0;
               state_in = S_EMIT1;
            end else begin
               wpx_in = PIX_W'(wx_ff) + PIX_W'(ox[sel]) + PIX_W'(1);
               wpy_in = PIX_W'(wy_ff) + PIX_W'(oy[sel]) + PIX_W'(1);
               wx_in = ox[sel]; wy_in = oy[sel];
               two_in = 1'b1;
               state_in = S_EMIT1;
            end
         end
         S_WMARK: begin
            wr_en = 1'b1;
            nb_in = 3'd0; mask_in = '0;
            state_in = S_NB;
         end
         S_EMIT1: begin
            if (out_free) begin
               res_in = make_item(KIND_PIXEL, fpx_ff, fpy_ff, fin_ff, lst_ff);
               rv_in = 1'b1;
               state_in = two_ff ? S_EMIT2 : S_IDLE;
            end
         end
         S_EMIT2: begin
            if (out_free) begin
               res_in = make_item(KIND_PIXEL, wpx_ff, wpy_ff, 1'b0, 1'b1);
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // hunt scan order: y inner, x outer
      if (advance) begin
         if (!y_wrap) begin
            hy_in = hy_ff + YW'(1); state_in = S_HCELL;
         end else if (!x_end) begin
            hy_in = '0; hx_in = hx_ff + XW'(1); state_in = S_HCELL;
         end else begin
            fin_in = 1'b1; lst_in = 1'b1; two_in = 1'b0; state_in = S_EMIT1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; gw_ff <= GRID_RESET; gh_ff <= GRID_RESET;
         wx_ff <= XW'(RST_W / 2); wy_ff <= YW'(RST_H / 2);
         hx_ff <= '0; hy_ff <= '0;
         hunt_ff <= 1'b0; rv_ff <= 1'b0; nb_ff <= 3'd0; pend_ff <= 1'b0;
         mask_ff <= '0; rh_ff <= '0; rw_ff <= '0;
         fpx_ff <= '0; fpy_ff <= '0; wpx_ff <= '0; wpy_ff <= '0;
         fin_ff <= 1'b0; lst_ff <= 1'b0; two_ff <= 1'b0; res_ff <= '0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; gw_ff <= gw_in; gh_ff <= gh_in;
         wx_ff <= wx_in; wy_ff <= wy_in; hx_ff <= hx_in; hy_ff <= hy_in;
         hunt_ff <= hunt_in; rv_ff <= rv_in; nb_ff <= nb_in; pend_ff <= pend_in;
         mask_ff <= mask_in; rh_ff <= rh_in; rw_ff <= rw_in;
         fpx_ff <= fpx_in; fpy_ff <= fpy_in; wpx_ff <= wpx_in; wpy_ff <= wpy_in;
         fin_ff <= fin_in; lst_ff <= lst_in; two_ff <= two_in; res_ff <= res_in;
      end
   end

   hkmg_visited_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rsp_valid    = rv_ff;
   assign rsp_kind     = res_ff.kind;
   assign rsp_pix_x    = res_ff.pix_x;
   assign rsp_pix_y    = res_ff.pix_y;
   assign rsp_finished = res_ff.finished;
   assign rsp_last     = res_ff.last;
endmodule
`default_nettype wire

>>> verif/hunt_and_kill_maze_generator_checker.sv
// Checker for the hunt-and-kill maze generator: watches the req, rsp and csr ports,
// predicts each item with its own maze state and compares kind, pixels and flags in order.
// Depends on hkmg_pkg.
`timescale 1ns / 100ps
module hunt_and_kill_maze_generator_checker
   import hkmg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic              req_op,
   input  wire logic [RAND_W-1:0] req_rand_hunt,
   input  wire logic [RAND_W-1:0] req_rand_walk,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_stall,
   input  wire logic              rsp_kind,
   input  wire logic [PIX_W-1:0]  rsp_pix_x,
   input  wire logic [PIX_W-1:0]  rsp_pix_y,
   input  wire logic              rsp_finished,
   input  wire logic              rsp_last,
   input  wire logic              csr_wr_en,
   input  wire logic              csr_index,
   input  wire logic [DIM_W-1:0]  csr_data,
   output int                     fail_count,
   output int                     outstanding
);
   localparam int MW = MAX_WIDTH_DEF;
   localparam int MH = MAX_HEIGHT_DEF;

   bit               visited [MW*MH];
   int               walker_x, walker_y;
   bit               hunting;
   logic [DIM_W-1:0] width_reg, height_reg;
   rsp_item_type     pixel_q[$];

   assign outstanding = pixel_q.size();

   function automatic int clamp_dim(logic [DIM_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
   endfunction

   function automatic int cell_idx(int x, int y);
      return (y % MH) * MW + (x % MW);
   endfunction

   function automatic int find_nbrs(int x, int y, int w, int h, bit want,
                                    output int nx[4], output int ny[4]);
      int n;
      n = 0;
      if (x >= 1 && visited[cell_idx(x - 1, y)] == want) begin
         nx[n] = x - 1; ny[n] = y; n++;
      end
      if (y >= 1 && visited[cell_idx(x, y - 1)] == want) begin
         nx[n] = x; ny[n] = y - 1; n++;
      end
      if (x + 1 < w && visited[cell_idx(x + 1, y)] == want) begin
         nx[n] = x + 1; ny[n] = y; n++;
      end
      if (y + 1 < h && visited[cell_idx(x, y + 1)] == want) begin
         nx[n] = x; ny[n] = y + 1; n++;
      end
      return n;
   endfunction

   function automatic rsp_item_type mk(logic k, int px, int py, logic fin, logic lst);
      rsp_item_type r;
      r.kind = k;
      r.pix_x = PIX_W'(px);
      r.pix_y = PIX_W'(py);
      r.finished = fin;
      r.last = lst;
      return r;
   endfunction

   task automatic queue_item(rsp_item_type r);
      pixel_q = {pixel_q, r};
   endtask

   task automatic restart_maze();
      foreach (visited[i]) visited[i] = 0;
      walker_x = clamp_dim(width_reg, MW) / 2;
      walker_y = clamp_dim(height_reg, MH) / 2;
      hunting = 0;
   endtask

   task automatic carve_step(logic op, logic [RAND_W-1:0] rh, logic [RAND_W-1:0] rw);
      int w, h, n, pick, nx[4], ny[4];
      bit found;
      rsp_item_type first;
      w = clamp_dim(width_reg, MW);
      h = clamp_dim(height_reg, MH);
      if (op == OP_RESTART) begin
         restart_maze();
         queue_item(mk(KIND_RESTART, 0, 0, 0, 1));
         return;
      end
      if (walker_x >= w) walker_x = w - 1;
      if (walker_y >= h) walker_y = h - 1;
      first = mk(KIND_PIXEL, 2 * walker_x + 1, 2 * walker_y + 1, 0, 0);
      if (hunting) begin
         found = 0;
         for (int x = 0; x < w && !found; x++) begin
            for (int y = 0; y < h && !found; y++) begin
               if (!visited[cell_idx(x, y)]) begin
                  n = find_nbrs(x, y, w, h, 1, nx, ny);
                  if (n != 0) begin
                     pick = int'(rh) % n;
                     walker_x = nx[pick];
                     walker_y = ny[pick];
                     found = 1;
                  end
               end
            end
         end
         if (!found) begin
            first.finished = 1;
            first.last = 1;
            queue_item(first);
            return;
         end
         hunting = 0;
      end
      visited[cell_idx(walker_x, walker_y)] = 1;
      n = find_nbrs(walker_x, walker_y, w, h, 0, nx, ny);
      if (n == 0) begin
         hunting = 1;
         first.last = 1;
         queue_item(first);
         return;
      end
      queue_item(first);
      pick = int'(rw) % n;
      queue_item(mk(KIND_PIXEL, walker_x + nx[pick] + 1, walker_y + ny[pick] + 1, 0, 1));
      walker_x = nx[pick];
      walker_y = ny[pick];
   endtask

   task automatic report(string what, int got, int want);
      fail_count++;
      if (fail_count <= 30)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_item_type e;
      if (reset) begin
         fail_count = 0;
         width_reg = GRID_RESET;
         height_reg = GRID_RESET;
         restart_maze();
         pixel_q.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_WIDTH) width_reg = csr_data;
            else height_reg = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pixel_q.size() == 0) begin
               report("unexpected item", 1, 0);
            end else begin
               e = pixel_q.pop_front();
               if (rsp_kind !== e.kind) report("kind", rsp_kind, e.kind);
               if (rsp_pix_x !== e.pix_x) report("pix_x", rsp_pix_x, e.pix_x);
               if (rsp_pix_y !== e.pix_y) report("pix_y", rsp_pix_y, e.pix_y);
               if (rsp_finished !== e.finished)
                  report("finished", rsp_finished, e.finished);
               if (rsp_last !== e.last) report("last", rsp_last, e.last);
            end
         end
         if (req_valid && !req_stall) carve_step(req_op, req_rand_hunt, req_rand_walk);
      end
   end
endmodule

>>> verif/hunt_and_kill_maze_generator_tb.sv
// Testbench top for the hunt-and-kill maze generator: clock, reset, stimulus and verdict.
// Depends on hkmg_pkg, hunt_and_kill_maze_generator and its checker.
`timescale 1ns / 100ps
module hunt_and_kill_maze_generator_tb;
   import hkmg_pkg::*;

   localparam logic OP_STEP = ~OP_RESTART;
   localparam int   IDLE_LIMIT = 300000;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_stall;
   logic              req_op = OP_STEP;
   logic [RAND_W-1:0] req_rand_hunt = '0;
   logic [RAND_W-1:0] req_rand_walk = '0;
   logic              rsp_valid;
   logic              rsp_stall = 0;
   logic              rsp_kind, rsp_finished, rsp_last;
   logic [PIX_W-1:0]  rsp_pix_x, rsp_pix_y;
   logic              csr_wr_en = 0;
   logic              csr_index = CSR_WIDTH;
   logic [DIM_W-1:0]  csr_data = '0;
   int                fail_count, outstanding;
   int                item_count = 0, restart_count = 0, done_count = 0, size_count = 0;
   int                idle_cycles = 0;
   bit                quiet = 0;

   always #5 clock = ~clock;

   hunt_and_kill_maze_generator dut (.*);
   hunt_and_kill_maze_generator_checker chk (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall && rsp_finished) done_count <= done_count + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_stall = 0;
            n = $urandom_range(1, 20);
         end else begin
            rsp_stall = 1;
            n = $urandom_range(1, 17);
         end
         repeat (n) @(negedge clock);
      end
   end

   task automatic send(logic op, logic [RAND_W-1:0] rh, logic [RAND_W-1:0] rw);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid = 1;
      req_op = op;
      req_rand_hunt = rh;
      req_rand_walk = rw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      item_count++;
      if (op == OP_RESTART) restart_count++;
   endtask

   task automatic drain();
      req_valid = 0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic set_grid(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
      drain();
      csr_wr_en = 1;
      csr_index = CSR_WIDTH;
      csr_data = w;
      @(negedge clock);
      csr_index = CSR_HEIGHT;
      csr_data = h;
      @(negedge clock);
      csr_wr_en = 0;
      size_count++;
   endtask

   function automatic logic [RAND_W-1:0] pick_rand();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return RAND_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // one maze: optional restart, the given number of steps plus one, some restarts as noise
   task automatic run_maze(int steps, bit do_restart);
      if (do_restart) send(OP_RESTART, pick_rand(), pick_rand());
      for (int i = 0; i < steps; i++) begin
         if ($urandom_range(0, 39) == 0) send(OP_RESTART, pick_rand(), pick_rand());
         else send(OP_STEP, pick_rand(), pick_rand());
      end
      send(OP_STEP, pick_rand(), pick_rand());
   endtask

   initial begin
      int w, h;
      repeat (11) @(negedge clock);
      reset = 0;

      // reset size 16x16, extreme random values
      send(OP_RESTART, '0, '0);
      send(OP_STEP, '0, '0);
      send(OP_STEP, '1, '1);
      send(OP_STEP, 16'h5555, 16'hAAAA);
      send(OP_STEP, '1, '0);
      drain();
      // single cell: walk, then completion repeated
      set_grid(7'd1, 7'd1);
      send(OP_STEP, '0, '0);
      send(OP_STEP, '1, '1);
      send(OP_STEP, '1, '1);
      send(OP_RESTART, '0, '0);
      send(OP_STEP, '0, '1);
      send(OP_STEP, '0, '1);
      // zero acts as one, walker clamped from old position
      set_grid(7'd0, 7'd0);
      run_maze(3, 0);
      set_grid(7'd64, 7'd64);
      run_maze(20, 1);
      set_grid(7'd127, 7'd100);
      run_maze(12, 0);
      set_grid(7'd2, 7'd3);
      run_maze(14, 0);
      set_grid(7'd3, 7'd2);
      run_maze(14, 1);

      while (item_count < 1600) begin
         if (item_count > 1400) quiet = 1;
         w = $urandom_range(1, 8);
         h = $urandom_range(1, 8);
         set_grid(7'(w), 7'(h));
         if (size_count == 12) begin
            send(OP_RESTART, '0, '0);
            send(OP_STEP, pick_rand(), pick_rand());
            drain();
         end
         run_maze(2 * w * h + $urandom_range(0, 6), $urandom_range(0, 3) != 0);
      end

      drain();
      repeat (50) @(negedge clock);
      $display("covered %0d items (%0d restarts) over %0d grid sizes, %0d completions",
               item_count, restart_count, size_count, done_count);
      if (fail_count == 0 && outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
